FILE: rtl/core/sbwcc_pkg.sv
// Shared types and constants for the 16-bit word CPU core.
`default_nettype none
package sbwcc_pkg;

    localparam int MEM_WORDS_DEF = 65536;
    localparam int WORD_W        = 16;
    localparam int NUM_REGS      = 8;
    localparam int DIV_STEPS     = 4;
    localparam int DIV_ITERS     = 8;

    typedef enum logic [1:0] {
        CMD_STEP = 2'd0,
        CMD_MWR  = 2'd1,
        CMD_MRD  = 2'd2,
        CMD_RRD  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NOP = 4'h0,
        OP_SET = 4'h1,
        OP_ADD = 4'h2,
        OP_SUB = 4'h3,
        OP_MUL = 4'h4,
        OP_DIV = 4'h5,
        OP_MOD = 4'h6,
        OP_SHL = 4'h7,
        OP_SHR = 4'h8,
        OP_AND = 4'h9,
        OP_BOR = 4'ha,
        OP_XOR = 4'hb,
        OP_IFE = 4'hc,
        OP_IFN = 4'hd,
        OP_IFG = 4'he,
        OP_IFB = 4'hf
    } t_op;

    localparam logic [5:0] CODE_IND    = 6'h08;
    localparam logic [5:0] CODE_IDX    = 6'h10;
    localparam logic [5:0] CODE_POP    = 6'h18;
    localparam logic [5:0] CODE_PEEK   = 6'h19;
    localparam logic [5:0] CODE_PUSH   = 6'h1a;
    localparam logic [5:0] CODE_SP     = 6'h1b;
    localparam logic [5:0] CODE_PC     = 6'h1c;
    localparam logic [5:0] CODE_OV     = 6'h1d;
    localparam logic [5:0] CODE_NWIND  = 6'h1e;
    localparam logic [5:0] CODE_NWLIT  = 6'h1f;

    typedef enum logic [2:0] {
        K_LIT,
        K_REG,
        K_MEM,
        K_SP,
        K_PC,
        K_OV
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] where;
        logic [15:0] lit;
    } t_opnd;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_SA,
        PH_SB
    } t_phase;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MRD,
        ST_FETCH,
        ST_FETCH_W,
        ST_RES,
        ST_RES_W,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_LOAD_C,
        ST_EXEC,
        ST_DIV,
        ST_WB,
        ST_SKIP_F,
        ST_SKIP_W,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/sixteen_bit_word_cpu_core.sv
// Top level of the 16-bit word CPU core: sequencer, register file and word memory.
`default_nettype none
// After reset the core clears its memory, one word per cycle, and takes no command
// until that pass ends. A memory write or register read goes straight to the result
// state; a memory read first waits for the registered read data. A step runs through
// fetch, two operand decodes, two operand loads, execute, write back and result, with
// a memory read for each next word it reads; a conditional that passes and the
// reserved opcode skip the write back. DIV and MOD by a nonzero divisor also pass
// through the radix-16 divider. A failed conditional then fetches the next
// instruction and decodes its operands, reading its next words, to skip it. The
// single-port word memory has a registered read. A result is held in an output
// register while the next command is taken.
module sixteen_bit_word_cpu_core
    import sbwcc_pkg::*;
#(
    parameter int MEMORY_WORDS = MEM_WORDS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cmd_valid,
    output logic        o_cmd_ready,
    input  wire  [1:0]  i_command,
    input  wire  [15:0] i_location,
    input  wire  [15:0] i_write_value,
    output logic        o_res_valid,
    input  wire         i_res_ready,
    output logic [15:0] o_read_value,
    output logic [15:0] o_pc_value,
    output logic [15:0] o_sp_value,
    output logic [15:0] o_overflow_value,
    output logic        o_skipped_next
);

    localparam int AW   = $clog2(MEMORY_WORDS);
    localparam int NMUL = 65536 / MEMORY_WORDS;

    function automatic logic [AW-1:0] mem_idx(input logic [15:0] x);
        logic [15:0] r;
        r = x;
        for (int k = 1; k < NMUL + 1; k++) begin
            if ({16'b0, x} >= 32'(k * MEMORY_WORDS)) begin
                r = x - 16'(k * MEMORY_WORDS);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [15:0] r_mem [MEMORY_WORDS];
    logic [15:0] r_rdata;
    logic          n_mre, n_mwe;
    logic [AW-1:0] n_maddr;
    logic [15:0]   n_mwd;

    logic [15:0] r_regs [NUM_REGS];
    logic        n_rwe;
    logic [2:0]  n_rwidx;
    logic [15:0] n_rwd;
    logic [2:0]  ridx;
    logic [15:0] rv;

    t_state      r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [15:0] r_pc, n_pc, r_sp, n_sp, r_ov, n_ov;
    logic [15:0] r_ins, n_ins;
    logic [5:0]  r_code, n_code;
    t_phase      r_phase, n_phase;
    t_opnd       r_la, n_la, r_lb, n_lb;
    logic [15:0] r_a, n_a, r_b, n_b;
    logic [15:0] r_res, n_res, r_ovn, n_ovn;
    logic        r_setov, n_setov, r_wr, n_wr;
    logic        r_skip, n_skip;
    logic [15:0] r_rd, n_rd, r_sp_save, n_sp_save;
    logic [31:0] r_quo, n_quo;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_dcnt, n_dcnt;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_o_rd, n_o_rd, r_o_pc, n_o_pc, r_o_sp, n_o_sp, r_o_ov, n_o_ov;
    logic        r_o_skip, n_o_skip;

    always_ff @(posedge i_clk) begin
        if (n_mwe) begin
            r_mem[n_maddr] <= n_mwd;
        end
        if (n_mre) begin
            r_rdata <= r_mem[n_maddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_regs[k] <= '0;
            end
        end else if (n_rwe) begin
            r_regs[n_rwidx] <= n_rwd;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE:   ridx = i_location[2:0];
            ST_LOAD_B: ridx = r_la.where[2:0];
            ST_LOAD_C: ridx = r_lb.where[2:0];
            default:   ridx = r_code[2:0];
        endcase
    end
    assign rv = r_regs[ridx];

    function automatic logic [15:0] load_val(input t_opnd l, input logic [15:0] md,
                                             input logic [15:0] rg, input logic [15:0] sp,
                                             input logic [15:0] pc, input logic [15:0] ov);
        logic [15:0] v;
        unique case (l.kind)
            K_REG:   v = rg;
            K_MEM:   v = md;
            K_SP:    v = sp;
            K_PC:    v = pc;
            K_OV:    v = ov;
            default: v = l.lit;
        endcase
        return v;
    endfunction

    always_comb begin
        t_opnd       cur;
        logic        fin;
        logic [16:0] sum;
        logic [31:0] prod, full;
        logic [16:0] dr;
        logic [31:0] dq;
        logic        skp;
        n_state   = r_state;
        n_clr     = r_clr;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_ov      = r_ov;
        n_ins     = r_ins;
        n_code    = r_code;
        n_phase   = r_phase;
        n_la      = r_la;
        n_lb      = r_lb;
        n_a       = r_a;
        n_b       = r_b;
        n_res     = r_res;
        n_ovn     = r_ovn;
        n_setov   = r_setov;
        n_wr      = r_wr;
        n_skip    = r_skip;
        n_rd      = r_rd;
        n_sp_save = r_sp_save;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_ovalid  = r_ovalid && !i_res_ready;
        n_o_rd    = r_o_rd;
        n_o_pc    = r_o_pc;
        n_o_sp    = r_o_sp;
        n_o_ov    = r_o_ov;
        n_o_skip  = r_o_skip;
        n_mre     = 1'b0;
        n_mwe     = 1'b0;
        n_maddr   = mem_idx(r_pc);
        n_mwd     = '0;
        n_rwe     = 1'b0;
        n_rwidx   = r_la.where[2:0];
        n_rwd     = r_res;
        o_cmd_ready = 1'b0;
        cur       = '{kind: K_LIT, where: 16'h0, lit: 16'h0};
        fin       = 1'b0;
        sum       = '0;
        prod      = '0;
        full      = '0;
        dr        = '0;
        dq        = '0;
        skp       = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                n_mwe   = 1'b1;
                n_maddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(MEMORY_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_skip  = 1'b0;
                    n_rd    = '0;
                    n_maddr = mem_idx(i_location);
                    unique case (t_cmd'(i_command))
                        CMD_STEP: n_state = ST_FETCH;
                        CMD_MWR: begin
                            n_mwe   = 1'b1;
                            n_mwd   = i_write_value;
                            n_state = ST_DONE;
                        end
                        CMD_MRD: begin
                            n_mre   = 1'b1;
                            n_state = ST_MRD;
                        end
                        default: begin
                            n_rd    = rv;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MRD: begin
                n_rd    = r_rdata;
                n_state = ST_DONE;
            end
            ST_FETCH: begin
                n_mre   = 1'b1;
                n_pc    = r_pc + 16'd1;
                n_state = ST_FETCH_W;
            end
            ST_FETCH_W: begin
                n_ins   = r_rdata;
                n_code  = r_rdata[9:4];
                n_phase = PH_A;
                n_state = ST_RES;
            end
            ST_RES: begin
                if (r_code < CODE_IND) begin
                    cur.kind  = K_REG;
                    cur.where = {13'b0, r_code[2:0]};
                    fin = 1'b1;
                end else if (r_code < CODE_IDX) begin
                    cur.kind  = K_MEM;
                    cur.where = rv;
                    fin = 1'b1;
                end else if (r_code < CODE_POP || r_code == CODE_NWIND ||
                             r_code == CODE_NWLIT) begin
                    n_mre   = 1'b1;
                    n_pc    = r_pc + 16'd1;
                    n_state = ST_RES_W;
                end else if (r_code == CODE_POP) begin
                    cur.kind  = K_MEM;
                    cur.where = r_sp;
                    n_sp = r_sp + 16'd1;
                    fin = 1'b1;
                end else if (r_code == CODE_PEEK) begin
                    cur.kind  = K_MEM;
                    cur.where = r_sp;
                    fin = 1'b1;
                end else if (r_code == CODE_PUSH) begin
                    cur.kind  = K_MEM;
                    cur.where = r_sp - 16'd1;
                    n_sp = r_sp - 16'd1;
                    fin = 1'b1;
                end else if (r_code == CODE_SP) begin
                    cur.kind = K_SP;
                    fin = 1'b1;
                end else if (r_code == CODE_PC) begin
                    cur.kind = K_PC;
                    fin = 1'b1;
                end else if (r_code == CODE_OV) begin
                    cur.kind = K_OV;
                    fin = 1'b1;
                end else begin
                    cur.lit = {11'b0, r_code[4:0]};
                    fin = 1'b1;
                end
            end
            ST_RES_W: begin
                fin = 1'b1;
                if (r_code == CODE_NWLIT) begin
                    cur.lit = r_rdata;
                end else if (r_code == CODE_NWIND) begin
                    cur.kind  = K_MEM;
                    cur.where = r_rdata;
                end else begin
                    cur.kind  = K_MEM;
                    cur.where = r_rdata + rv;
                end
            end
            ST_LOAD_A: begin
                n_maddr = mem_idx(r_la.where);
                n_mre   = (r_la.kind == K_MEM);
                n_state = ST_LOAD_B;
            end
            ST_LOAD_B: begin
                n_a     = load_val(r_la, r_rdata, rv, r_sp, r_pc, r_ov);
                n_maddr = mem_idx(r_lb.where);
                n_mre   = (r_lb.kind == K_MEM);
                n_state = ST_LOAD_C;
            end
            ST_LOAD_C: begin
                n_b     = load_val(r_lb, r_rdata, rv, r_sp, r_pc, r_ov);
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_setov = 1'b0;
                n_wr    = 1'b1;
                n_state = ST_WB;
                unique case (t_op'(r_ins[3:0]))
                    OP_SET: n_res = r_b;
                    OP_ADD: begin
                        sum     = {1'b0, r_a} + {1'b0, r_b};
                        n_res   = sum[15:0];
                        n_ovn   = {15'b0, sum[16]};
                        n_setov = 1'b1;
                    end
                    OP_SUB: begin
                        n_res   = r_a - r_b;
                        n_ovn   = (r_a < r_b) ? 16'hffff : 16'h0;
                        n_setov = 1'b1;
                    end
                    OP_MUL: begin
                        prod    = r_a * r_b;
                        n_res   = prod[15:0];
                        n_ovn   = prod[31:16];
                        n_setov = 1'b1;
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_b == 16'h0) begin
                            n_res   = '0;
                            n_ovn   = '0;
                            n_setov = (r_ins[3:0] == OP_DIV);
                        end else begin
                            n_quo   = (r_ins[3:0] == OP_DIV) ? {r_a, 16'h0} : {16'h0, r_a};
                            n_rem   = '0;
                            n_dcnt  = '0;
                            n_state = ST_DIV;
                        end
                    end
                    OP_SHL: begin
                        full    = (r_b < 16'd32) ? ({16'h0, r_a} << r_b[4:0]) : 32'h0;
                        n_res   = full[15:0];
                        n_ovn   = full[31:16];
                        n_setov = 1'b1;
                    end
                    OP_SHR: begin
                        full    = (r_b < 16'd32) ? ({r_a, 16'h0} >> r_b[4:0]) : 32'h0;
                        n_res   = full[31:16];
                        n_ovn   = full[15:0];
                        n_setov = 1'b1;
                    end
                    OP_AND: n_res = r_a & r_b;
                    OP_BOR: n_res = r_a | r_b;
                    OP_XOR: n_res = r_a ^ r_b;
                    OP_IFE, OP_IFN, OP_IFG, OP_IFB: begin
                        case (t_op'(r_ins[3:0]))
                            OP_IFE:  skp = (r_a != r_b);
                            OP_IFN:  skp = (r_a == r_b);
                            OP_IFG:  skp = (r_a <= r_b);
                            default: skp = ((r_a & r_b) == 16'h0);
                        endcase
                        n_wr    = 1'b0;
                        n_state = skp ? ST_SKIP_F : ST_DONE;
                    end
                    default: begin
                        n_wr    = 1'b0;
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DIV: begin
                dr = {1'b0, r_rem};
                dq = r_quo;
                for (int k = 0; k < DIV_STEPS; k++) begin
                    dr = {dr[15:0], dq[31]};
                    dq = {dq[30:0], 1'b0};
                    if (dr >= {1'b0, r_b}) begin
                        dr    = dr - {1'b0, r_b};
                        dq[0] = 1'b1;
                    end
                end
                n_quo  = dq;
                n_rem  = dr[15:0];
                n_dcnt = r_dcnt + 3'd1;
                if (r_dcnt == 3'(DIV_ITERS - 1)) begin
                    n_state = ST_WB;
                    if (r_ins[3:0] == OP_DIV) begin
                        n_res   = dq[31:16];
                        n_ovn   = dq[15:0];
                        n_setov = 1'b1;
                    end else begin
                        n_res   = dr[15:0];
                        n_setov = 1'b0;
                    end
                end
            end
            ST_WB: begin
                if (r_setov) begin
                    n_ov = r_ovn;
                end
                if (r_wr) begin
                    unique case (r_la.kind)
                        K_REG: n_rwe = 1'b1;
                        K_MEM: begin
                            n_mwe   = 1'b1;
                            n_maddr = mem_idx(r_la.where);
                            n_mwd   = r_res;
                        end
                        K_SP:    n_sp = r_res;
                        K_PC:    n_pc = r_res;
                        K_OV:    n_ov = r_res;
                        default: ;
                    endcase
                end
                n_state = ST_DONE;
            end
            ST_SKIP_F: begin
                n_sp_save = r_sp;
                n_mre     = 1'b1;
                n_pc      = r_pc + 16'd1;
                n_state   = ST_SKIP_W;
            end
            ST_SKIP_W: begin
                n_ins   = r_rdata;
                n_code  = r_rdata[9:4];
                n_phase = PH_SA;
                n_state = ST_RES;
            end
            default: begin
                if (!r_ovalid || i_res_ready) begin
                    n_ovalid = 1'b1;
                    n_o_rd   = r_rd;
                    n_o_pc   = r_pc;
                    n_o_sp   = r_sp;
                    n_o_ov   = r_ov;
                    n_o_skip = r_skip;
                    n_state  = ST_IDLE;
                end
            end
        endcase

        if (fin) begin
            n_state = ST_RES;
            unique case (r_phase)
                PH_A: begin
                    n_la    = cur;
                    n_code  = r_ins[15:10];
                    n_phase = PH_B;
                end
                PH_B: begin
                    n_lb    = cur;
                    n_state = ST_LOAD_A;
                end
                PH_SA: begin
                    n_code  = r_ins[15:10];
                    n_phase = PH_SB;
                end
                default: begin
                    n_sp    = r_sp_save;
                    n_skip  = 1'b1;
                    n_state = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_sp     <= '0;
            r_ov     <= '0;
            r_ovalid <= 1'b0;
            r_phase  <= PH_A;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pc     <= n_pc;
            r_sp     <= n_sp;
            r_ov     <= n_ov;
            r_ovalid <= n_ovalid;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins     <= n_ins;
        r_code    <= n_code;
        r_la      <= n_la;
        r_lb      <= n_lb;
        r_a       <= n_a;
        r_b       <= n_b;
        r_res     <= n_res;
        r_ovn     <= n_ovn;
        r_setov   <= n_setov;
        r_wr      <= n_wr;
        r_skip    <= n_skip;
        r_rd      <= n_rd;
        r_sp_save <= n_sp_save;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dcnt    <= n_dcnt;
        r_o_rd    <= n_o_rd;
        r_o_pc    <= n_o_pc;
        r_o_sp    <= n_o_sp;
        r_o_ov    <= n_o_ov;
        r_o_skip  <= n_o_skip;
    end

    assign o_res_valid      = r_ovalid;
    assign o_read_value     = r_o_rd;
    assign o_pc_value       = r_o_pc;
    assign o_sp_value       = r_o_sp;
    assign o_overflow_value = r_o_ov;
    assign o_skipped_next   = r_o_skip;

endmodule
`default_nettype wire

FILE: tb/sixteen_bit_word_cpu_core_test.sv
// Self-checking testbench for the 16-bit word CPU core: commands, instruction set, backpressure.
`default_nettype none
module sixteen_bit_word_cpu_core_test
    import sbwcc_pkg::*;
();

    localparam int MEMW = 65536;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [15:0] rd;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [15:0] ov;
        logic        skp;
    } t_outcome;

    typedef struct {
        t_kind       kind;
        logic [15:0] where;
        logic [15:0] lit;
    } t_loc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic [1:0]  command = '0;
    logic [15:0] location = '0;
    logic [15:0] write_value = '0;
    logic        res_ready = 1'b0;
    wire         cmd_ready;
    wire         res_valid;
    wire  [15:0] read_value, pc_value, sp_value, overflow_value;
    wire         skipped_next;

    logic [15:0] mem_model [MEMW];
    logic [15:0] gpr [8];
    logic [15:0] pc_m, sp_m, ov_m;

    t_outcome    expected_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_off = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          stall_mode = 0;

    sixteen_bit_word_cpu_core #(.MEMORY_WORDS(MEMW)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_command(command), .i_location(location), .i_write_value(write_value),
        .o_res_valid(res_valid), .i_res_ready(res_ready),
        .o_read_value(read_value), .o_pc_value(pc_value), .o_sp_value(sp_value),
        .o_overflow_value(overflow_value), .o_skipped_next(skipped_next)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [15:0] fetch_word();
        logic [15:0] w;
        w = mem_model[pc_m];
        pc_m = pc_m + 16'd1;
        return w;
    endfunction

    function automatic t_loc decode_operand(logic [5:0] code);
        t_loc l;
        l.kind = K_LIT;
        l.where = '0;
        l.lit = '0;
        if (code < CODE_IND) begin
            l.kind = K_REG;
            l.where = {13'd0, code[2:0]};
        end else if (code < CODE_IDX) begin
            l.kind = K_MEM;
            l.where = gpr[code[2:0]];
        end else if (code < CODE_POP) begin
            l.kind = K_MEM;
            l.where = fetch_word() + gpr[code[2:0]];
        end else if (code == CODE_POP) begin
            l.kind = K_MEM;
            l.where = sp_m;
            sp_m = sp_m + 16'd1;
        end else if (code == CODE_PEEK) begin
            l.kind = K_MEM;
            l.where = sp_m;
        end else if (code == CODE_PUSH) begin
            sp_m = sp_m - 16'd1;
            l.kind = K_MEM;
            l.where = sp_m;
        end else if (code == CODE_SP) begin
            l.kind = K_SP;
        end else if (code == CODE_PC) begin
            l.kind = K_PC;
        end else if (code == CODE_OV) begin
            l.kind = K_OV;
        end else if (code == CODE_NWIND) begin
            l.kind = K_MEM;
            l.where = fetch_word();
        end else if (code == CODE_NWLIT) begin
            l.lit = fetch_word();
        end else begin
            l.lit = {11'd0, code[4:0]};
        end
        return l;
    endfunction

    function automatic logic [15:0] operand_value(t_loc l);
        case (l.kind)
            K_REG: return gpr[l.where[2:0]];
            K_MEM: return mem_model[l.where];
            K_SP: return sp_m;
            K_PC: return pc_m;
            K_OV: return ov_m;
            default: return l.lit;
        endcase
    endfunction

    function automatic void write_operand(t_loc l, logic [15:0] w);
        case (l.kind)
            K_REG: gpr[l.where[2:0]] = w;
            K_MEM: mem_model[l.where] = w;
            K_SP: sp_m = w;
            K_PC: pc_m = w;
            K_OV: ov_m = w;
            default: ;
        endcase
    endfunction

    function automatic logic execute_instruction();
        logic [15:0] ins, saved_sp, nxt;
        t_loc la, lb, dummy;
        logic [31:0] a, b, q;
        logic [63:0] full;
        logic skip;
        t_op op;
        ins = fetch_word();
        op = t_op'(ins[3:0]);
        la = decode_operand(ins[9:4]);
        lb = decode_operand(ins[15:10]);
        a = {16'd0, operand_value(la)};
        b = {16'd0, operand_value(lb)};
        skip = 1'b0;
        case (op)
            OP_SET: write_operand(la, b[15:0]);
            OP_ADD: begin
                q = a + b;
                ov_m = q[16] ? 16'd1 : 16'd0;
                write_operand(la, q[15:0]);
            end
            OP_SUB: begin
                ov_m = (a < b) ? 16'hffff : 16'd0;
                write_operand(la, a[15:0] - b[15:0]);
            end
            OP_MUL: begin
                q = a * b;
                ov_m = q[31:16];
                write_operand(la, q[15:0]);
            end
            OP_DIV: begin
                if (b != 0) begin
                    q = (a << 16) / b;
                    ov_m = q[15:0];
                    q = a / b;
                    write_operand(la, q[15:0]);
                end else begin
                    ov_m = '0;
                    write_operand(la, 16'd0);
                end
            end
            OP_MOD: begin
                q = (b != 0) ? a % b : 32'd0;
                write_operand(la, q[15:0]);
            end
            OP_SHL: begin
                full = (b < 32) ? ({32'd0, a} << b) : 64'd0;
                ov_m = full[31:16];
                write_operand(la, full[15:0]);
            end
            OP_SHR: begin
                full = (b < 32) ? (({32'd0, a} << 16) >> b) : 64'd0;
                ov_m = full[15:0];
                write_operand(la, full[31:16]);
            end
            OP_AND: write_operand(la, a[15:0] & b[15:0]);
            OP_BOR: write_operand(la, a[15:0] | b[15:0]);
            OP_XOR: write_operand(la, a[15:0] ^ b[15:0]);
            OP_IFE: skip = (a != b);
            OP_IFN: skip = (a == b);
            OP_IFG: skip = (a <= b);
            OP_IFB: skip = ((a & b) == 0);
            default: ;
        endcase
        if (skip) begin
            saved_sp = sp_m;
            nxt = fetch_word();
            dummy = decode_operand(nxt[9:4]);
            dummy = decode_operand(nxt[15:10]);
            sp_m = saved_sp;
        end
        return skip;
    endfunction

    function automatic t_outcome predict_command(t_cmd c, logic [15:0] loc, logic [15:0] val);
        t_outcome r;
        r.rd = '0;
        r.skp = 1'b0;
        case (c)
            CMD_STEP: r.skp = execute_instruction();
            CMD_MWR: mem_model[loc] = val;
            CMD_MRD: r.rd = mem_model[loc];
            default: r.rd = gpr[loc[2:0]];
        endcase
        r.pc = pc_m;
        r.sp = sp_m;
        r.ov = ov_m;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic send_command(t_cmd c, logic [15:0] loc, logic [15:0] val);
        if ($urandom_range(0, 3) == 0) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        cmd_valid <= 1'b1;
        command <= c;
        location <= loc;
        write_value <= val;
        expected_q.push_back(predict_command(c, loc, val));
        @(posedge i_clk);
        while (!cmd_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_instruction(logic [15:0] ins, logic [15:0] w1, logic [15:0] w2);
        send_command(CMD_MWR, pc_m, ins);
        send_command(CMD_MWR, pc_m + 16'd1, w1);
        send_command(CMD_MWR, pc_m + 16'd2, w2);
        send_command(CMD_STEP, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] encode(t_op op, logic [5:0] ca, logic [5:0] cb);
        return {cb, ca, op};
    endfunction

    task automatic test_host_access();
        send_command(CMD_MWR, 16'hffff, 16'hffff);
        send_command(CMD_MRD, 16'hffff, 16'h0000);
        send_command(CMD_MWR, 16'h0000, 16'h0000);
        send_command(CMD_MRD, 16'h0000, 16'hffff);
        send_command(CMD_RRD, 16'hfff8, 16'h1234);
        send_command(CMD_RRD, 16'h0007, 16'h0000);
    endtask

    task automatic test_each_opcode();
        for (int op = 0; op < 16; op++)
            run_instruction(encode(t_op'(op), 6'h00, 6'h1f), 16'hffff, 16'h0);
        run_instruction(encode(OP_SET, 6'h01, 6'h20), 16'd0, 16'd0);
        run_instruction(encode(OP_DIV, 6'h00, 6'h01), 16'd0, 16'd0);
        run_instruction(encode(OP_MOD, 6'h00, 6'h01), 16'd0, 16'd0);
        run_instruction(encode(OP_SHL, 6'h00, 6'h1f), 16'd40, 16'd0);
        run_instruction(encode(OP_SET, 6'h3f, 6'h00), 16'd0, 16'd0);
        run_instruction(encode(OP_IFE, 6'h00, 6'h3f), 16'd0, 16'd0);
        run_instruction(encode(OP_SET, 6'h1a, 6'h1f), 16'h8000, 16'd0);
        run_instruction(encode(OP_SET, 6'h1c, 6'h1f), 16'hfffe, 16'd0);
    endtask

    task automatic test_random_programs(int n);
        logic [5:0] ca, cb;
        t_op op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: send_command(CMD_MWR, 16'($urandom), 16'($urandom));
                1: send_command(CMD_MRD, ($urandom_range(0, 1)) ? 16'($urandom) : pc_m,
                                16'($urandom));
                2: send_command(CMD_RRD, 16'($urandom), 16'($urandom));
                3: send_command(CMD_STEP, 16'($urandom), 16'($urandom));
                default: begin
                    op = t_op'($urandom_range(0, 15));
                    ca = 6'($urandom_range(0, 63));
                    cb = 6'($urandom_range(0, 63));
                    if (ca == CODE_PC && $urandom_range(0, 3) != 0) ca = 6'h00;
                    run_instruction(encode(op, ca, cb),
                                    ($urandom_range(0, 1)) ? 16'($urandom_range(0, 40))
                                                           : 16'($urandom),
                                    16'($urandom));
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 20; i++)
            send_command(CMD_RRD, 16'($urandom), 16'd0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_valid && res_ready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result transfer");
                errors++;
            end else begin
                t_outcome e;
                e = expected_q.pop_front();
                if (read_value !== e.rd) report_mismatch("read_value", read_value, e.rd);
                if (pc_value !== e.pc) report_mismatch("pc_value", pc_value, e.pc);
                if (sp_value !== e.sp) report_mismatch("sp_value", sp_value, e.sp);
                if (overflow_value !== e.ov)
                    report_mismatch("overflow_value", overflow_value, e.ov);
                if (skipped_next !== e.skp)
                    report_mismatch("skipped_next", {15'd0, skipped_next}, {15'd0, e.skp});
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_off = 300;
        end
        if (hold_off > 0) begin
            hold_off--;
            res_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 2) != 0);
                default: res_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < MEMW; k++) mem_model[k] = '0;
        for (int k = 0; k < 8; k++) gpr[k] = '0;
        pc_m = '0;
        sp_m = '0;
        ov_m = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_host_access();
        test_each_opcode();
        test_backpressure();
        test_random_programs(700);
        cmd_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
